FILE: rtl/core/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned MaxBytes = 65536;
  localparam int unsigned CntW     = 17;
  localparam int unsigned TdataInW = 8;
  localparam int unsigned TdataOutW = 40;
  localparam int unsigned TuserOutW = 3;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxBytes);

  typedef enum logic [2:0] {
    ST_RUNNING = 3'd0,
    ST_VALID   = 3'd1,
    ST_NUL     = 3'd2,
    ST_INVALID = 3'd3,
    ST_SKIPPED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    RULE_NORMAL = 3'd0,
    RULE_AFTER_E0 = 3'd1,
    RULE_AFTER_ED = 3'd2,
    RULE_AFTER_F0 = 3'd3,
    RULE_AFTER_F4 = 3'd4
  } rule_e;

  typedef struct packed {
    logic [CntW-1:0] pos;
    logic [CntW-1:0] chars;
    logic [CntW-1:0] lead;
    logic [1:0]      pending;
    rule_e           rule;
    logic            stopped;
  } state_t;

  typedef struct packed {
    status_e         status;
    logic [CntW-1:0] char_count;
    logic [CntW-1:0] end_offset;
  } result_t;

  localparam state_t StateClear = '{
    pos: '0, chars: '0, lead: '0, pending: 2'd0, rule: RULE_NORMAL, stopped: 1'b0
  };

endpackage

FILE: rtl/core/utf8_stream_validator_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_core
// UTF-8 (RFC 3629) stream checker, one byte per beat.
//
// Input stream: one string byte per beat in s_axis_tdata, s_axis_tlast on the
// final byte of a buffer. Output stream: one result beat per input beat,
// status in m_axis_tuser, character count and end offset in m_axis_tdata.
// An accepted input beat sits in the input register, and its result beat
// is then moved into the result register, from which it is presented.
// Throughput is one byte per cycle as long as the receiver takes each
// result beat; the per-byte check and the state update are combinational
// logic that sits between those two registers.
// When the receiver stalls, the result register holds its beat and the
// input register refills once; s_axis_tready then drops until the result
// is taken. Reset clears all validator state and empties both registers,
// so the next byte starts a fresh buffer. A buffer's state also clears
// after its last byte.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [utf8v_pkg::TdataInW-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic                               s_axis_tlast,   // last_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [utf8v_pkg::TdataOutW-1:0]    m_axis_tdata,   // [16:0] char_count,
                                                             // [33:17] end_offset
  output logic [utf8v_pkg::TuserOutW-1:0]    m_axis_tuser    // [2:0] status
);

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;
  logic                 out_valid_q;
  utf8v_pkg::result_t   out_q;
  utf8v_pkg::result_t   res_d;
  utf8v_pkg::state_t    state_q;
  utf8v_pkg::state_t    state_d;
  logic                 out_free;
  logic                 advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  utf8v_step u_step (
    .state_i     (state_q),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= utf8v_pkg::StateClear;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {6'b0, out_q.end_offset, out_q.char_count};

endmodule

FILE: rtl/core/utf8v_step.sv
// ----------------------------------------------------------------------------
// utf8v_step
// Next-state and result logic for one byte of the validator.
// ----------------------------------------------------------------------------
module utf8v_step (
  input  utf8v_pkg::state_t  state_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output utf8v_pkg::state_t  state_o,
  output utf8v_pkg::result_t result_o
);

  function automatic logic [utf8v_pkg::CntW-1:0] sat_inc(
    input logic [utf8v_pkg::CntW-1:0] v
  );
    logic [utf8v_pkg::CntW-1:0] r;
    r = (v >= utf8v_pkg::MaxCnt) ? utf8v_pkg::MaxCnt : v + 1'b1;
    return r;
  endfunction

  function automatic logic cont_ok(input logic [7:0] b, input utf8v_pkg::rule_e rule);
    logic ok;
    case (rule)
      utf8v_pkg::RULE_AFTER_E0: ok = (b[7:5] == 3'b101);
      utf8v_pkg::RULE_AFTER_ED: ok = (b[7:5] == 3'b100);
      utf8v_pkg::RULE_AFTER_F0: ok = (b[7:6] == 2'b10) && (b[5:4] != 2'b00);
      utf8v_pkg::RULE_AFTER_F4: ok = (b[7:4] == 4'b1000);
      default:                  ok = (b[7:6] == 2'b10);
    endcase
    return ok;
  endfunction

  logic                         halt;
  utf8v_pkg::status_e           halt_status;
  logic [utf8v_pkg::CntW-1:0]   halt_off;
  utf8v_pkg::state_t            nxt;

  always_comb begin
    nxt         = state_i;
    halt        = 1'b0;
    halt_status = utf8v_pkg::ST_INVALID;
    halt_off    = state_i.pos;
    result_o    = '{status: utf8v_pkg::ST_RUNNING, char_count: state_i.chars, end_offset: '0};

    if (state_i.stopped) begin
      result_o = '{status: utf8v_pkg::ST_SKIPPED, char_count: state_i.chars,
                   end_offset: state_i.lead};
      if (last_byte_i) begin
        nxt = utf8v_pkg::StateClear;
      end
    end else begin
      nxt.pos = sat_inc(state_i.pos);
      if (state_i.pending == 2'd0) begin
        if (data_byte_i == 8'h00) begin
          halt        = 1'b1;
          halt_status = utf8v_pkg::ST_NUL;
        end else if (!data_byte_i[7]) begin
          nxt.chars = sat_inc(state_i.chars);
        end else if (data_byte_i < 8'hc2 || data_byte_i >= 8'hf5) begin
          halt = 1'b1;
        end else begin
          nxt.lead = state_i.pos;
          if (data_byte_i < 8'he0) begin
            nxt.pending = 2'd1;
            nxt.rule    = utf8v_pkg::RULE_NORMAL;
          end else if (data_byte_i < 8'hf0) begin
            nxt.pending = 2'd2;
            nxt.rule    = (data_byte_i[3:0] == 4'h0) ? utf8v_pkg::RULE_AFTER_E0 :
                          (data_byte_i[3:0] == 4'hd) ? utf8v_pkg::RULE_AFTER_ED :
                                                       utf8v_pkg::RULE_NORMAL;
          end else begin
            nxt.pending = 2'd3;
            nxt.rule    = (data_byte_i[2:0] == 3'd0) ? utf8v_pkg::RULE_AFTER_F0 :
                          (data_byte_i[2:0] == 3'd4) ? utf8v_pkg::RULE_AFTER_F4 :
                                                       utf8v_pkg::RULE_NORMAL;
          end
        end
      end else begin
        if (!cont_ok(data_byte_i, state_i.rule)) begin
          halt     = 1'b1;
          halt_off = state_i.lead;
        end else begin
          nxt.pending = state_i.pending - 2'd1;
          nxt.rule    = utf8v_pkg::RULE_NORMAL;
          if (state_i.pending == 2'd1) begin
            nxt.chars = sat_inc(state_i.chars);
          end
        end
      end

      if (halt) begin
        result_o = '{status: halt_status, char_count: state_i.chars, end_offset: halt_off};
        if (last_byte_i) begin
          nxt = utf8v_pkg::StateClear;
        end else begin
          nxt.stopped = 1'b1;
          nxt.lead    = halt_off;
          nxt.pending = 2'd0;
          nxt.rule    = utf8v_pkg::RULE_NORMAL;
          nxt.chars   = state_i.chars;
        end
      end else if (last_byte_i) begin
        if (nxt.pending != 2'd0) begin
          result_o = '{status: utf8v_pkg::ST_INVALID, char_count: nxt.chars,
                       end_offset: nxt.lead};
        end else begin
          result_o = '{status: utf8v_pkg::ST_VALID, char_count: nxt.chars,
                       end_offset: nxt.pos};
        end
        nxt = utf8v_pkg::StateClear;
      end else begin
        result_o = '{status: utf8v_pkg::ST_RUNNING, char_count: nxt.chars, end_offset: '0};
      end
    end
  end

  assign state_o = nxt;

endmodule

FILE: sim/utf8_stream_validator_core_test.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_core_test
// Self-checking bench for the UTF-8 stream validator core.
//
// Byte buffers go in on the input stream, one byte per beat. Each result
// beat is checked against a model of the validator that the bench keeps in
// step with every accepted beat. Directed buffers cover the RFC 3629
// boundaries and the stop and skip cases. Random buffers are mostly
// well-formed text with some corruption and noise. Both sides idle at random,
// and once the result side holds off long enough to fill the core.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned PhaseItems = 490;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [utf8v_pkg::TdataInW-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tlast  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [utf8v_pkg::TdataOutW-1:0] m_axis_tdata;
  logic [utf8v_pkg::TuserOutW-1:0] m_axis_tuser;

  utf8v_pkg::state_t  text_state = utf8v_pkg::StateClear;
  utf8v_pkg::result_t expected_results[$];
  logic [7:0]         buffer_bytes[$];
  int unsigned        src_idle_pct  = 0;
  int unsigned        sink_idle_pct = 0;
  int unsigned        holds_asked   = 0;
  int unsigned        holds_done    = 0;
  int unsigned        hold_left     = 0;
  int unsigned        bytes_sent    = 0;
  int unsigned        stall_cycles  = 0;
  int unsigned        errors        = 0;

  utf8_stream_validator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10ns clk_i = ~clk_i;
  end

  function automatic logic [utf8v_pkg::CntW-1:0] count_up(
    input logic [utf8v_pkg::CntW-1:0] v
  );
    return (v >= utf8v_pkg::MaxCnt) ? utf8v_pkg::MaxCnt : v + 1'b1;
  endfunction

  function automatic bit cont_fits(input logic [7:0] b, input utf8v_pkg::rule_e rule);
    case (rule)
      utf8v_pkg::RULE_AFTER_E0: return b[7:5] == 3'b101;
      utf8v_pkg::RULE_AFTER_ED: return b[7:5] == 3'b100;
      utf8v_pkg::RULE_AFTER_F0: return (b[7:6] == 2'b10) && (b[5:4] != 2'b00);
      utf8v_pkg::RULE_AFTER_F4: return b[7:4] == 4'b1000;
      default:                  return b[7:6] == 2'b10;
    endcase
  endfunction

  function automatic utf8v_pkg::result_t stop_text(input utf8v_pkg::status_e st,
                                                   input logic [utf8v_pkg::CntW-1:0] off,
                                                   input logic last);
    utf8v_pkg::result_t r;
    r = '{status: st, char_count: text_state.chars, end_offset: off};
    if (last) begin
      text_state = utf8v_pkg::StateClear;
    end else begin
      text_state.stopped = 1'b1;
      text_state.lead    = off;
      text_state.pending = 2'd0;
      text_state.rule    = utf8v_pkg::RULE_NORMAL;
    end
    return r;
  endfunction

  function automatic utf8v_pkg::result_t check_byte(input logic [7:0] b, input logic last);
    logic [utf8v_pkg::CntW-1:0] here;
    utf8v_pkg::result_t         r;
    here = text_state.pos;
    if (text_state.stopped) begin
      r = '{status: utf8v_pkg::ST_SKIPPED, char_count: text_state.chars,
            end_offset: text_state.lead};
      if (last) text_state = utf8v_pkg::StateClear;
      return r;
    end
    text_state.pos = count_up(text_state.pos);
    if (text_state.pending == 2'd0) begin
      if (b == 8'h00) return stop_text(utf8v_pkg::ST_NUL, here, last);
      if (b < 8'h80) begin
        text_state.chars = count_up(text_state.chars);
      end else if (b < 8'hC2 || b >= 8'hF5) begin
        return stop_text(utf8v_pkg::ST_INVALID, here, last);
      end else begin
        text_state.lead = here;
        if (b < 8'hE0) begin
          text_state.pending = 2'd1;
          text_state.rule    = utf8v_pkg::RULE_NORMAL;
        end else if (b < 8'hF0) begin
          text_state.pending = 2'd2;
          text_state.rule    = (b[3:0] == 4'h0) ? utf8v_pkg::RULE_AFTER_E0 :
                               (b[3:0] == 4'hD) ? utf8v_pkg::RULE_AFTER_ED :
                                                  utf8v_pkg::RULE_NORMAL;
        end else begin
          text_state.pending = 2'd3;
          text_state.rule    = (b[2:0] == 3'd0) ? utf8v_pkg::RULE_AFTER_F0 :
                               (b[2:0] == 3'd4) ? utf8v_pkg::RULE_AFTER_F4 :
                                                  utf8v_pkg::RULE_NORMAL;
        end
      end
    end else begin
      if (!cont_fits(b, text_state.rule)) begin
        return stop_text(utf8v_pkg::ST_INVALID, text_state.lead, last);
      end
      text_state.pending = text_state.pending - 2'd1;
      text_state.rule    = utf8v_pkg::RULE_NORMAL;
      if (text_state.pending == 2'd0) text_state.chars = count_up(text_state.chars);
    end
    if (last) begin
      if (text_state.pending != 2'd0) begin
        r = '{status: utf8v_pkg::ST_INVALID, char_count: text_state.chars,
              end_offset: text_state.lead};
      end else begin
        r = '{status: utf8v_pkg::ST_VALID, char_count: text_state.chars,
              end_offset: text_state.pos};
      end
      text_state = utf8v_pkg::StateClear;
    end else begin
      r = '{status: utf8v_pkg::ST_RUNNING, char_count: text_state.chars, end_offset: '0};
    end
    return r;
  endfunction

  function automatic void compare_field(input string what, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(check_byte(b, last));
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (buffer_bytes[i]) send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
    buffer_bytes.delete();
  endtask

  task automatic add_char();
    logic [7:0] lead;
    case ($urandom_range(0, 3))
      0: buffer_bytes.push_back(rand_byte(8'h01, 8'h7F));
      1: begin
        buffer_bytes.push_back(rand_byte(8'hC2, 8'hDF));
        buffer_bytes.push_back(rand_byte(8'h80, 8'hBF));
      end
      2: begin
        lead = rand_byte(8'hE0, 8'hEF);
        buffer_bytes.push_back(lead);
        buffer_bytes.push_back((lead == 8'hE0) ? rand_byte(8'hA0, 8'hBF) :
                               (lead == 8'hED) ? rand_byte(8'h80, 8'h9F) :
                                                 rand_byte(8'h80, 8'hBF));
        buffer_bytes.push_back(rand_byte(8'h80, 8'hBF));
      end
      default: begin
        lead = rand_byte(8'hF0, 8'hF4);
        buffer_bytes.push_back(lead);
        buffer_bytes.push_back((lead == 8'hF0) ? rand_byte(8'h90, 8'hBF) :
                               (lead == 8'hF4) ? rand_byte(8'h80, 8'h8F) :
                                                 rand_byte(8'h80, 8'hBF));
        buffer_bytes.push_back(rand_byte(8'h80, 8'hBF));
        buffer_bytes.push_back(rand_byte(8'h80, 8'hBF));
      end
    endcase
  endtask

  task automatic test_char_boundaries();
    buffer_bytes = '{8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
                     8'hED, 8'h9F, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_buffer();
  endtask

  task automatic test_nul_and_skip();
    buffer_bytes = '{8'h41, 8'h00, 8'h80};
    send_buffer();
    buffer_bytes = '{8'h80, 8'hF5, 8'hFF};
    send_buffer();
  endtask

  task automatic test_rejected_forms();
    buffer_bytes = '{8'hC0};
    send_buffer();
    buffer_bytes = '{8'hE0, 8'h9F};
    send_buffer();
    buffer_bytes = '{8'hED, 8'hA0};
    send_buffer();
    buffer_bytes = '{8'hF0, 8'h8F};
    send_buffer();
    buffer_bytes = '{8'hF4, 8'h90};
    send_buffer();
    buffer_bytes = '{8'hE2, 8'h00};
    send_buffer();
    buffer_bytes = '{8'hE2, 8'h82};
    send_buffer();
  endtask

  task automatic test_random_text(input int unsigned items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bytes_sent + items;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 8)) buffer_bytes.push_back(rand_byte(0, 255));
      end else begin
        repeat ($urandom_range(1, 12)) add_char();
        if (pick < 20) begin
          buffer_bytes[$urandom_range(0, buffer_bytes.size() - 1)] = rand_byte(0, 255);
        end else if (pick < 28 && buffer_bytes.size() > 1) begin
          void'(buffer_bytes.pop_back());
        end else if (pick < 33) begin
          buffer_bytes[$urandom_range(0, buffer_bytes.size() - 1)] = 8'h00;
        end
      end
      send_buffer();
    end
  endtask

  task automatic test_backpressure();
    holds_asked <= holds_asked + 1;
    repeat (40) add_char();
    send_buffer();
  endtask

  always @(posedge clk_i) begin : result_side
    utf8v_pkg::result_t got;
    utf8v_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{status:     utf8v_pkg::status_e'(m_axis_tuser),
              char_count: m_axis_tdata[utf8v_pkg::CntW-1:0],
              end_offset: m_axis_tdata[2*utf8v_pkg::CntW-1:utf8v_pkg::CntW]};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %0h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("char_count", want.char_count, got.char_count);
        compare_field("end_offset", want.end_offset, got.end_offset);
      end
    end
    if (holds_asked != holds_done) begin
      holds_done = holds_asked;
      hold_left  = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("[utf8_stream_validator_core] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct  = 34;
    sink_idle_pct = 79;
    test_char_boundaries();
    test_nul_and_skip();
    test_rejected_forms();
    test_random_text(PhaseItems);

    src_idle_pct  = 79;
    sink_idle_pct = 34;
    test_random_text(PhaseItems);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_backpressure();
    test_random_text(PhaseItems);

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[utf8_stream_validator_core] OK");
    end else begin
      $display("[utf8_stream_validator_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/utf8v_pkg.sv
rtl/core/utf8v_step.sv
rtl/core/utf8_stream_validator_core.sv
sim/utf8_stream_validator_core_test.sv
